@@ hdl/sfd_pkg.sv @@
// shared types, codes and crc function of the sensor frame deframer
package sfd_pkg;

  localparam int BYTE_W      = 8;
  localparam int CFG_INDEX_W = 8;
  localparam int KIND_W      = 2;
  localparam int SEQ_W       = 32;
  localparam int ACK_W       = 16;

  localparam logic [KIND_W-1:0] KIND_PAYLOAD   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_FRAME_OK  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_CRC_ERROR = 2'd2;

  localparam logic [BYTE_W-1:0] CRC_INIT = 8'hFF;
  localparam logic [BYTE_W-1:0] CRC_POLY = 8'h31;
  localparam logic [BYTE_W-1:0] CRC_TOP  = 8'h80;

  localparam logic [BYTE_W-1:0] RESET_FIRST_HDR  = 8'hAA;
  localparam logic [BYTE_W-1:0] RESET_SECOND_HDR = 8'h55;

  localparam logic [CFG_INDEX_W-1:0] REG_FIRST_HDR  = 8'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_SECOND_HDR = 8'd1;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [BYTE_W-1:0] payload_byte;
    logic [BYTE_W-1:0] payload_length;
    logic [SEQ_W-1:0]  sequence_number;
    logic [ACK_W-1:0]  ack_number;
    logic [BYTE_W-1:0] sensor_type;
  } result_t;

  // bytewise crc-8, msb first, no final xor
  function automatic logic [BYTE_W-1:0] crc8_update(input logic [BYTE_W-1:0] crc,
                                                    input logic [BYTE_W-1:0] data);
    logic [BYTE_W-1:0] c;
    c = crc ^ data;
    for (int k = 0; k < BYTE_W; k++) begin
      if ((c & CRC_TOP) != '0) begin
        c = (c << 1) ^ CRC_POLY;
      end else begin
        c = c << 1;
      end
    end
    return c;
  endfunction

endpackage

@@ hdl/sfd_parser.sv @@
// frame parser: phase machine, running crc and header field capture
module sfd_parser (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          step,
  input  logic [sfd_pkg::BYTE_W-1:0]    rx_byte,
  input  logic [sfd_pkg::BYTE_W-1:0]    first_hdr,
  input  logic [sfd_pkg::BYTE_W-1:0]    second_hdr,
  output logic                          res_valid,
  output sfd_pkg::result_t              res
);

  typedef enum logic [7:0] {
    PH_HDR1    = 8'b0000_0001,
    PH_HDR2    = 8'b0000_0010,
    PH_LEN     = 8'b0000_0100,
    PH_SEQ     = 8'b0000_1000,
    PH_ACK     = 8'b0001_0000,
    PH_SENSOR  = 8'b0010_0000,
    PH_PAYLOAD = 8'b0100_0000,
    PH_CRC     = 8'b1000_0000
  } phase_t;

  phase_t                         phase, phase_next;
  logic [sfd_pkg::BYTE_W-1:0]     cnt, cnt_next, cnt_inc;
  logic [sfd_pkg::BYTE_W-1:0]     crc, crc_next, crc_upd, crc_fresh;
  logic [sfd_pkg::BYTE_W-1:0]     len, len_next;
  logic [sfd_pkg::SEQ_W-1:0]      seq, seq_next;
  logic [sfd_pkg::ACK_W-1:0]      ack, ack_next;
  logic [sfd_pkg::BYTE_W-1:0]     sensor, sensor_next;

  always_comb begin
    phase_next  = phase;
    cnt_next    = cnt;
    crc_next    = crc;
    len_next    = len;
    seq_next    = seq;
    ack_next    = ack;
    sensor_next = sensor;
    cnt_inc     = cnt + 8'd1;
    crc_upd     = sfd_pkg::crc8_update(crc, rx_byte);
    crc_fresh   = sfd_pkg::crc8_update(sfd_pkg::CRC_INIT, rx_byte);
    res_valid   = 1'b0;
    res.kind            = sfd_pkg::KIND_PAYLOAD;
    res.payload_byte    = rx_byte;
    res.payload_length  = len;
    res.sequence_number = seq;
    res.ack_number      = ack;
    res.sensor_type     = sensor;
    case (phase)
      PH_HDR1: begin
        if (rx_byte == first_hdr) begin
          crc_next   = crc_fresh;
          phase_next = PH_HDR2;
        end
      end
      PH_HDR2: begin
        if (rx_byte == second_hdr) begin
          crc_next   = crc_upd;
          phase_next = PH_LEN;
        end else if (rx_byte == first_hdr) begin
          crc_next = crc_fresh;
        end else begin
          phase_next = PH_HDR1;
        end
      end
      PH_LEN: begin
        crc_next   = crc_upd;
        len_next   = rx_byte;
        seq_next   = '0;
        cnt_next   = '0;
        phase_next = PH_SEQ;
      end
      PH_SEQ: begin
        crc_next = crc_upd;
        seq_next = seq | ({24'd0, rx_byte} << {cnt[1:0], 3'b000});
        cnt_next = cnt_inc;
        if (cnt_inc >= 8'd4) begin
          cnt_next   = '0;
          ack_next   = '0;
          phase_next = PH_ACK;
        end
      end
      PH_ACK: begin
        crc_next = crc_upd;
        ack_next = ack | ({8'd0, rx_byte} << {cnt[0], 3'b000});
        cnt_next = cnt_inc;
        if (cnt_inc >= 8'd2) begin
          cnt_next   = '0;
          phase_next = PH_SENSOR;
        end
      end
      PH_SENSOR: begin
        crc_next    = crc_upd;
        sensor_next = rx_byte;
        cnt_next    = '0;
        phase_next  = (len == '0) ? PH_CRC : PH_PAYLOAD;
      end
      PH_PAYLOAD: begin
        crc_next  = crc_upd;
        res_valid = 1'b1;
        cnt_next  = cnt_inc;
        if (cnt_inc >= len) begin
          cnt_next   = '0;
          phase_next = PH_CRC;
        end
      end
      PH_CRC: begin
        res_valid        = 1'b1;
        res.kind         = (rx_byte == crc) ? sfd_pkg::KIND_FRAME_OK
                                            : sfd_pkg::KIND_CRC_ERROR;
        res.payload_byte = '0;
        cnt_next         = '0;
        crc_next         = sfd_pkg::CRC_INIT;
        phase_next       = PH_HDR1;
      end
      default: begin
        phase_next = PH_HDR1;
        cnt_next   = '0;
        crc_next   = sfd_pkg::CRC_INIT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase  <= PH_HDR1;
      cnt    <= '0;
      crc    <= sfd_pkg::CRC_INIT;
      len    <= '0;
      seq    <= '0;
      ack    <= '0;
      sensor <= '0;
    end else if (step) begin
      phase  <= phase_next;
      cnt    <= cnt_next;
      crc    <= crc_next;
      len    <= len_next;
      seq    <= seq_next;
      ack    <= ack_next;
      sensor <= sensor_next;
    end
  end

endmodule

@@ hdl/sfd_out_stage.sv @@
// result register towards the output channel
module sfd_out_stage (
  input  logic              clk,
  input  logic              rst,
  input  logic              load,
  input  sfd_pkg::result_t  res,
  input  logic              out_stall,
  output logic              out_valid,
  output logic              free,
  output sfd_pkg::result_t  res_q
);

  assign free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_q <= res;
    end
  end

endmodule

@@ hdl/sensor_frame_deframer_core.sv @@
// top level of the sensor frame deframer
// Streaming deframer for sensor frames: two sync bytes (set by registers 0
// and 1), a length byte, a little-endian 32-bit sequence, a little-endian
// 16-bit ack, a sensor-type byte, the payload and a trailing crc-8 (poly
// 0x31, init 0xff, msb first) over every earlier frame byte. Each payload
// byte comes out as its own transfer (kind 0) carrying the frame's header
// fields; the crc byte gives one frame transfer, kind 1 when the crc matches
// and kind 2 when it does not, in which case the payload already sent is to
// be dropped downstream. Header, length, sequence, ack and sensor-type bytes
// give no output. The block takes one byte every cycle while its input side
// is not stalled: a byte goes into the input register, is parsed and crc-updated
// there, and its result lands in the output register until the consumer takes
// it. The parse step sets the rate; the input side stalls only while the
// output register holds a result the consumer has not taken and the byte
// waiting to be parsed would give another.
// The configuration port is always ready and should be written only while
// no byte or result is in flight.
module sensor_frame_deframer_core (
  input  logic                               clk,
  input  logic                               rst,
  // byte input channel
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [sfd_pkg::BYTE_W-1:0]         rx_byte,
  // result channel
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [sfd_pkg::KIND_W-1:0]         kind,
  output logic [sfd_pkg::BYTE_W-1:0]         payload_byte,
  output logic [sfd_pkg::BYTE_W-1:0]         payload_length,
  output logic [sfd_pkg::SEQ_W-1:0]          sequence_number,
  output logic [sfd_pkg::ACK_W-1:0]          ack_number,
  output logic [sfd_pkg::BYTE_W-1:0]         sensor_type,
  // configuration write channel
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [sfd_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [sfd_pkg::BYTE_W-1:0]         cfg_data
);

  // sync byte registers
  logic [sfd_pkg::BYTE_W-1:0] first_hdr;
  logic [sfd_pkg::BYTE_W-1:0] second_hdr;

  // input register
  logic                       s1_valid;
  logic [sfd_pkg::BYTE_W-1:0] s1_byte;

  logic             res_valid;
  sfd_pkg::result_t res;
  sfd_pkg::result_t res_q;
  logic             out_free;
  logic             advance;
  logic             step;
  logic             in_take;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      first_hdr  <= sfd_pkg::RESET_FIRST_HDR;
      second_hdr <= sfd_pkg::RESET_SECOND_HDR;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        sfd_pkg::REG_FIRST_HDR:  first_hdr  <= cfg_data;
        sfd_pkg::REG_SECOND_HDR: second_hdr <= cfg_data;
        default: ;  // unknown index, write dropped
      endcase
    end
  end

  // a byte that yields no result always moves on; one that yields a
  // result needs the output register free this cycle
  assign advance  = !res_valid || out_free;
  assign step     = s1_valid && advance;
  assign in_stall = s1_valid && !advance;
  assign in_take  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_take) begin
      s1_valid <= 1'b1;
    end else if (step) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_byte <= rx_byte;
    end
  end

  sfd_parser u_parser (
    .clk        (clk),
    .rst        (rst),
    .step       (step),
    .rx_byte    (s1_byte),
    .first_hdr  (first_hdr),
    .second_hdr (second_hdr),
    .res_valid  (res_valid),
    .res        (res)
  );

  sfd_out_stage u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (step && res_valid),
    .res       (res),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .free      (out_free),
    .res_q     (res_q)
  );

  assign kind            = res_q.kind;
  assign payload_byte    = res_q.payload_byte;
  assign payload_length  = res_q.payload_length;
  assign sequence_number = res_q.sequence_number;
  assign ack_number      = res_q.ack_number;
  assign sensor_type     = res_q.sensor_type;

`ifndef ASSERT_OFF
  // every result carries a defined kind code
  a_kind_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (kind == sfd_pkg::KIND_PAYLOAD || kind == sfd_pkg::KIND_FRAME_OK ||
                   kind == sfd_pkg::KIND_CRC_ERROR))
    else $error("result with undefined kind");

  // frame results carry a zero data byte
  a_frame_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && kind != sfd_pkg::KIND_PAYLOAD) |-> (payload_byte == '0))
    else $error("frame result with non-zero data byte");

  // input side stalls only with a byte waiting in the input register and a result blocked in the output register
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (s1_valid && out_valid && out_stall))
    else $error("input stalled without a blocked result");

  // a waiting byte is parsed whenever the output register can take its result
  a_drain: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && out_free) |-> step)
    else $error("input register not drained");
`endif

endmodule
